### rtl/core/pcap_pkg.sv
package pcap_pkg;

    localparam int COORD_W  = 24;
    localparam int RADIUS_W = 23;
    localparam int AREA_W   = 63;
    localparam int LEN_W    = 40;
    localparam int CROSS_W  = 58;

    localparam int MUL_W    = 25;
    localparam int PROD_W   = 2 * MUL_W;
    localparam int R2_W     = 2 * RADIUS_W;
    localparam int ACC_W    = 80;
    localparam int ACC_FRAC = 30;

    localparam int RAD_W    = 50;
    localparam int ROOT_W   = RAD_W / 2;
    localparam int REM_W    = ROOT_W + 1;

    localparam logic [31:0] PI_Q30 = 32'd3373259426;

    localparam logic signed [ACC_W-1:0] ACC_ROUND = ACC_W'(1) << (ACC_FRAC - 1);

    localparam logic [CROSS_W-1:0] CROSS_MAX = {1'b0, {(CROSS_W-1){1'b1}}};
    localparam logic [CROSS_W-1:0] CROSS_MIN = {1'b1, {(CROSS_W-1){1'b0}}};

    typedef struct packed {
        logic              done;
        logic [ROOT_W-1:0] root;
    } sqrt_res_t;

endpackage

### rtl/core/pcap_isqrt.sv
module pcap_isqrt (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [pcap_pkg::RAD_W-1:0]    radicand,
    output pcap_pkg::sqrt_res_t           res
);

    localparam int CNT_W = $clog2(pcap_pkg::ROOT_W + 1);
    localparam int SH_W  = pcap_pkg::REM_W + 2;

    logic [CNT_W-1:0]              cnt_reg;
    logic                          done_reg;
    logic [pcap_pkg::RAD_W-1:0]    rad_reg;
    logic [pcap_pkg::REM_W-1:0]    rem_reg;
    logic [pcap_pkg::ROOT_W-1:0]   root_reg;

    logic [SH_W-1:0]               rem_sh;
    logic [SH_W-1:0]               trial;
    logic [SH_W-1:0]               diff;
    logic                          fits;
    logic [pcap_pkg::REM_W-1:0]    rem_next;
    logic [pcap_pkg::ROOT_W-1:0]   root_next;

    // one result bit per cycle: restoring square root
    assign rem_sh    = {rem_reg, rad_reg[pcap_pkg::RAD_W-1 -: 2]};
    assign trial     = {1'b0, root_reg, 2'b01};
    assign diff      = rem_sh - trial;
    assign fits      = (rem_sh >= trial);
    assign rem_next  = fits ? diff[pcap_pkg::REM_W-1:0] : rem_sh[pcap_pkg::REM_W-1:0];
    assign root_next = {root_reg[pcap_pkg::ROOT_W-2:0], fits};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end else if (start) begin
            cnt_reg  <= CNT_W'(pcap_pkg::ROOT_W);
            done_reg <= 1'b0;
        end else if (cnt_reg != '0) begin
            cnt_reg <= cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1)) begin
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rad_reg  <= radicand;
            rem_reg  <= '0;
            root_reg <= '0;
        end else if (cnt_reg != '0) begin
            rad_reg  <= {rad_reg[pcap_pkg::RAD_W-3:0], 2'b00};
            rem_reg  <= rem_next;
            root_reg <= root_next;
        end
    end

    assign res.done = done_reg;
    assign res.root = root_reg;

endmodule

### rtl/core/polygon_circle_area_perimeter.sv
// Polygon and circle area/perimeter unit. Polygon vertices arrive one word at a
// time (signed Q15.8); s_last_vertex closes the shape and the block then returns
// floor(|shoelace sum|/2) as the area (Q.16) and the summed edge lengths as the
// perimeter (Q.8), both saturated. A circle word (s_op = 1) returns pi*r^2 and
// 2*pi*r, rounded half up. A vertex that opens a polygon and is not the last
// is only stored; each further vertex adds one edge, mostly spent in the
// 25-step bit-serial square root of the edge length, and the last vertex also
// adds the closing edge back to the first vertex before the result is posted.
// A circle runs on the one shared 25x25 multiplier and accumulator. A non-final
// vertex that would bring the count to MAX_VERTICES is dropped. s_ready is high
// only between words; a finished result waits in the output register.
module polygon_circle_area_perimeter #(
    parameter int MAX_VERTICES = 256
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic                                 s_op,
    input  logic signed [pcap_pkg::COORD_W-1:0]  s_x_coord,
    input  logic signed [pcap_pkg::COORD_W-1:0]  s_y_coord,
    input  logic [pcap_pkg::RADIUS_W-1:0]        s_radius,
    input  logic                                 s_last_vertex,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic [pcap_pkg::AREA_W-1:0]          m_area,
    output logic [pcap_pkg::LEN_W-1:0]           m_perimeter
);

    localparam int VCNT_W = $clog2(MAX_VERTICES);
    localparam int ST_W   = 5;

    localparam logic [ST_W-1:0] ST_IDLE  = 5'd0;
    localparam logic [ST_W-1:0] ST_C_RR  = 5'd1;
    localparam logic [ST_W-1:0] ST_C_P0  = 5'd2;
    localparam logic [ST_W-1:0] ST_C_P1  = 5'd3;
    localparam logic [ST_W-1:0] ST_C_P2  = 5'd4;
    localparam logic [ST_W-1:0] ST_C_A0  = 5'd5;
    localparam logic [ST_W-1:0] ST_C_A1  = 5'd6;
    localparam logic [ST_W-1:0] ST_C_A2  = 5'd7;
    localparam logic [ST_W-1:0] ST_C_A3  = 5'd8;
    localparam logic [ST_W-1:0] ST_C_OUT = 5'd9;
    localparam logic [ST_W-1:0] ST_E_DX  = 5'd10;
    localparam logic [ST_W-1:0] ST_E_DY  = 5'd11;
    localparam logic [ST_W-1:0] ST_E_XA  = 5'd12;
    localparam logic [ST_W-1:0] ST_E_XB  = 5'd13;
    localparam logic [ST_W-1:0] ST_E_CR  = 5'd14;
    localparam logic [ST_W-1:0] ST_E_CW  = 5'd15;
    localparam logic [ST_W-1:0] ST_E_SQ  = 5'd16;
    localparam logic [ST_W-1:0] ST_E_LW  = 5'd17;
    localparam logic [ST_W-1:0] ST_P_OUT = 5'd18;

    localparam int CW = pcap_pkg::COORD_W;
    localparam int AW = pcap_pkg::ACC_W;

    // control
    logic [ST_W-1:0]   state_reg, state_next;
    logic              started_reg;
    logic [VCNT_W-1:0] vcount_reg;
    logic              closing_reg;
    logic              m_valid_reg;

    // payload
    logic signed [CW-1:0]                    in_x_reg, in_y_reg;
    logic [pcap_pkg::RADIUS_W-1:0]           in_r_reg;
    logic                                    last_reg;
    logic signed [CW-1:0]                    first_x_reg, first_y_reg;
    logic signed [CW-1:0]                    prev_x_reg, prev_y_reg;
    logic signed [pcap_pkg::CROSS_W-1:0]     cross_reg;
    logic [pcap_pkg::LEN_W-1:0]              len_reg;
    logic signed [AW-1:0]                    acc_reg, acc_next;
    logic signed [pcap_pkg::PROD_W-1:0]      prod_reg, prod_next;
    logic [pcap_pkg::R2_W-1:0]               r2_reg;
    logic [pcap_pkg::LEN_W-1:0]              per_tmp_reg;
    logic [pcap_pkg::AREA_W-1:0]             m_area_reg;
    logic [pcap_pkg::LEN_W-1:0]              m_per_reg;

    logic                                    s_fire;
    logic                                    drop;
    logic                                    out_free;
    logic                                    out_load;
    logic signed [pcap_pkg::MUL_W-1:0]       mul_a, mul_b;
    logic signed [AW-1:0]                    acc_base, acc_addend, prod_ext;
    logic                                    acc_sub, acc_en;
    logic                                    sqrt_start;
    pcap_pkg::sqrt_res_t                     sqrt_res;

    logic signed [CW-1:0]                    bx, by;
    logic signed [pcap_pkg::MUL_W-1:0]       dx, dy;
    logic signed [pcap_pkg::MUL_W-1:0]       ax_op, ay_op, bx_op, by_op;
    logic signed [pcap_pkg::MUL_W-1:0]       r_op, pi_lo_op, pi_hi_op, r2_lo_op, r2_hi_op;
    logic signed [AW-1:0]                    cross_ext, len_ext, root_ext;
    logic [pcap_pkg::CROSS_W-1:0]            cross_sat;
    logic [pcap_pkg::LEN_W-1:0]              len_sat;
    logic [pcap_pkg::CROSS_W-1:0]            cross_mag;
    logic [AW-pcap_pkg::CROSS_W:0]           cross_hi;

    assign s_ready  = (state_reg == ST_IDLE);
    assign s_fire   = s_valid && s_ready;
    assign drop     = !s_last_vertex && (vcount_reg >= VCNT_W'(MAX_VERTICES - 1));
    assign out_free = !m_valid_reg || m_ready;
    assign out_load = out_free && ((state_reg == ST_C_OUT) || (state_reg == ST_P_OUT));

    // edge runs from prev to either the new vertex or back to the first one
    assign bx = closing_reg ? first_x_reg : in_x_reg;
    assign by = closing_reg ? first_y_reg : in_y_reg;
    assign dx = {bx[CW-1], bx} - {prev_x_reg[CW-1], prev_x_reg};
    assign dy = {by[CW-1], by} - {prev_y_reg[CW-1], prev_y_reg};

    assign ax_op    = {prev_x_reg[CW-1], prev_x_reg};
    assign ay_op    = {prev_y_reg[CW-1], prev_y_reg};
    assign bx_op    = {bx[CW-1], bx};
    assign by_op    = {by[CW-1], by};
    assign r_op     = {2'b00, in_r_reg};
    assign pi_lo_op = {9'd0, pcap_pkg::PI_Q30[15:0]};
    assign pi_hi_op = {9'd0, pcap_pkg::PI_Q30[31:16]};
    assign r2_lo_op = {2'b00, r2_reg[pcap_pkg::RADIUS_W-1:0]};
    assign r2_hi_op = {2'b00, r2_reg[pcap_pkg::R2_W-1:pcap_pkg::RADIUS_W]};

    assign prod_next = mul_a * mul_b;
    assign prod_ext  = {{(AW-pcap_pkg::PROD_W){prod_reg[pcap_pkg::PROD_W-1]}}, prod_reg};
    assign cross_ext = {{(AW-pcap_pkg::CROSS_W){cross_reg[pcap_pkg::CROSS_W-1]}}, cross_reg};
    assign len_ext   = {{(AW-pcap_pkg::LEN_W){1'b0}}, len_reg};
    assign root_ext  = {{(AW-pcap_pkg::ROOT_W){1'b0}}, sqrt_res.root};
    assign acc_next  = acc_sub ? (acc_base - acc_addend) : (acc_base + acc_addend);

    assign cross_hi  = acc_reg[AW-1:pcap_pkg::CROSS_W-1];
    assign cross_sat = ((cross_hi == '0) || (cross_hi == '1)) ? acc_reg[pcap_pkg::CROSS_W-1:0] :
                       acc_reg[AW-1] ? pcap_pkg::CROSS_MIN : pcap_pkg::CROSS_MAX;
    assign len_sat   = (acc_reg[AW-1:pcap_pkg::LEN_W] != '0) ? '1 :
                       acc_reg[pcap_pkg::LEN_W-1:0];
    assign cross_mag = cross_reg[pcap_pkg::CROSS_W-1] ?
                       (~cross_reg + pcap_pkg::CROSS_W'(1)) : cross_reg;

    pcap_isqrt u_isqrt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (sqrt_start),
        .radicand (acc_reg[pcap_pkg::RAD_W-1:0]),
        .res      (sqrt_res)
    );

    always_comb begin
        state_next = state_reg;
        mul_a      = '0;
        mul_b      = '0;
        acc_base   = acc_reg;
        acc_addend = '0;
        acc_sub    = 1'b0;
        acc_en     = 1'b0;
        sqrt_start = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    if (s_op) begin
                        state_next = ST_C_RR;
                    end else if (!started_reg) begin
                        state_next = s_last_vertex ? ST_E_DX : ST_IDLE;
                    end else if (!drop) begin
                        state_next = ST_E_DX;
                    end
                end
            end
            // circle: perimeter = 2*r*pi, area = r2*pi, pi split in 16-bit halves
            ST_C_RR: begin
                mul_a      = r_op;
                mul_b      = r_op;
                acc_base   = pcap_pkg::ACC_ROUND;
                acc_en     = 1'b1;
                state_next = ST_C_P0;
            end
            ST_C_P0: begin
                mul_a      = r_op;
                mul_b      = pi_lo_op;
                state_next = ST_C_P1;
            end
            ST_C_P1: begin
                mul_a      = r_op;
                mul_b      = pi_hi_op;
                acc_addend = prod_ext <<< 1;
                acc_en     = 1'b1;
                state_next = ST_C_P2;
            end
            ST_C_P2: begin
                mul_a      = r2_lo_op;
                mul_b      = pi_lo_op;
                acc_addend = prod_ext <<< 17;
                acc_en     = 1'b1;
                state_next = ST_C_A0;
            end
            ST_C_A0: begin
                mul_a      = r2_lo_op;
                mul_b      = pi_hi_op;
                acc_base   = pcap_pkg::ACC_ROUND;
                acc_addend = prod_ext;
                acc_en     = 1'b1;
                state_next = ST_C_A1;
            end
            ST_C_A1: begin
                mul_a      = r2_hi_op;
                mul_b      = pi_lo_op;
                acc_addend = prod_ext <<< 16;
                acc_en     = 1'b1;
                state_next = ST_C_A2;
            end
            ST_C_A2: begin
                mul_a      = r2_hi_op;
                mul_b      = pi_hi_op;
                acc_addend = prod_ext <<< 23;
                acc_en     = 1'b1;
                state_next = ST_C_A3;
            end
            ST_C_A3: begin
                acc_addend = prod_ext <<< 39;
                acc_en     = 1'b1;
                state_next = ST_C_OUT;
            end
            ST_C_OUT: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            // edge: dx^2 + dy^2 into the root, then the cross term
            ST_E_DX: begin
                mul_a      = dx;
                mul_b      = dx;
                state_next = ST_E_DY;
            end
            ST_E_DY: begin
                mul_a      = dy;
                mul_b      = dy;
                acc_base   = '0;
                acc_addend = prod_ext;
                acc_en     = 1'b1;
                state_next = ST_E_XA;
            end
            ST_E_XA: begin
                mul_a      = ax_op;
                mul_b      = by_op;
                acc_addend = prod_ext;
                acc_en     = 1'b1;
                state_next = ST_E_XB;
            end
            ST_E_XB: begin
                sqrt_start = 1'b1;
                mul_a      = bx_op;
                mul_b      = ay_op;
                acc_base   = cross_ext;
                acc_addend = prod_ext;
                acc_en     = 1'b1;
                state_next = ST_E_CR;
            end
            ST_E_CR: begin
                acc_addend = prod_ext;
                acc_sub    = 1'b1;
                acc_en     = 1'b1;
                state_next = ST_E_CW;
            end
            ST_E_CW: begin
                state_next = ST_E_SQ;
            end
            ST_E_SQ: begin
                if (sqrt_res.done) begin
                    acc_base   = len_ext;
                    acc_addend = root_ext;
                    acc_en     = 1'b1;
                    state_next = ST_E_LW;
                end
            end
            ST_E_LW: begin
                if (closing_reg) begin
                    state_next = ST_P_OUT;
                end else if (last_reg) begin
                    state_next = ST_E_DX;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_P_OUT: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            started_reg <= 1'b0;
            vcount_reg  <= '0;
            closing_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (s_fire && !s_op) begin
                if (!started_reg) begin
                    started_reg <= 1'b1;
                    vcount_reg  <= VCNT_W'(1);
                    closing_reg <= s_last_vertex;
                end else if (!drop) begin
                    closing_reg <= 1'b0;
                end
            end
            if ((state_reg == ST_E_LW) && !closing_reg) begin
                vcount_reg <= vcount_reg + VCNT_W'(1);
                if (last_reg) begin
                    closing_reg <= 1'b1;
                end
            end
            if ((state_reg == ST_P_OUT) && out_free) begin
                started_reg <= 1'b0;
                vcount_reg  <= '0;
            end
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        prod_reg <= prod_next;
        if (acc_en) begin
            acc_reg <= acc_next;
        end
        if (s_fire) begin
            in_x_reg <= s_x_coord;
            in_y_reg <= s_y_coord;
            in_r_reg <= s_radius;
            last_reg <= s_last_vertex;
        end
        if (s_fire && !s_op && !started_reg) begin
            first_x_reg <= s_x_coord;
            first_y_reg <= s_y_coord;
            prev_x_reg  <= s_x_coord;
            prev_y_reg  <= s_y_coord;
            cross_reg   <= '0;
            len_reg     <= '0;
        end
        if (state_reg == ST_C_P0) begin
            r2_reg <= prod_reg[pcap_pkg::R2_W-1:0];
        end
        if (state_reg == ST_C_A0) begin
            per_tmp_reg <= acc_reg[pcap_pkg::ACC_FRAC+pcap_pkg::LEN_W-1:pcap_pkg::ACC_FRAC];
        end
        if (state_reg == ST_E_CW) begin
            cross_reg <= cross_sat;
        end
        if (state_reg == ST_E_LW) begin
            len_reg <= len_sat;
            if (!closing_reg) begin
                prev_x_reg <= in_x_reg;
                prev_y_reg <= in_y_reg;
            end
        end
        if ((state_reg == ST_P_OUT) && out_free) begin
            cross_reg <= '0;
            len_reg   <= '0;
        end
        if (out_load) begin
            if (state_reg == ST_C_OUT) begin
                m_area_reg <= pcap_pkg::AREA_W'(acc_reg[AW-1:pcap_pkg::ACC_FRAC]);
                m_per_reg  <= per_tmp_reg;
            end else begin
                m_area_reg <= pcap_pkg::AREA_W'(cross_mag[pcap_pkg::CROSS_W-1:1]);
                m_per_reg  <= len_reg;
            end
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_area      = m_area_reg;
    assign m_perimeter = m_per_reg;

endmodule

### rtl/core/pcap_checker.sv
module pcap_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_valid,
    input logic                           s_ready,
    input logic                           s_op,
    input logic                           m_valid,
    input logic                           m_ready,
    input logic [pcap_pkg::AREA_W-1:0]    m_area,
    input logic [pcap_pkg::LEN_W-1:0]     m_perimeter
);

    // a stalled result word holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_area) && $stable(m_perimeter))
        else $error("result word changed while stalled");

    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid && s_ready)
        else $error("reset did not clear the result or reopen the input");

    // a circle word always starts the multiply sequence
    a_circle_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_op |=> !s_ready)
        else $error("circle word did not occupy the unit");

    // a new result only follows a busy cycle
    a_result_after_work: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> !$past(s_ready))
        else $error("result appeared without preceding work");

endmodule

bind polygon_circle_area_perimeter pcap_checker u_pcap_checker (
    .aclk        (aclk),
    .aresetn     (aresetn),
    .s_valid     (s_valid),
    .s_ready     (s_ready),
    .s_op        (s_op),
    .m_valid     (m_valid),
    .m_ready     (m_ready),
    .m_area      (m_area),
    .m_perimeter (m_perimeter)
);
